### sv/pva_pkg.sv
package pva_pkg;

  // Voice table size and derived index width.
  localparam int MAX_VOICES = 16;
  localparam int IDX_W      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

  // Field widths.
  localparam int NOTE_W  = 7;
  localparam int CTRL_W  = 7;
  localparam int LEVEL_W = 7;
  localparam int STAMP_W = 32;
  localparam int VIDX_W  = 4;
  localparam int COUNT_W = 5;
  localparam int ENTRY_W = NOTE_W + STAMP_W;

  // Configuration port.
  localparam int                ADDR_W           = 3;
  localparam int                DATA_W           = 32;
  localparam logic [ADDR_W-1:0] ADDR_VOICE_COUNT = 3'd0;
  localparam logic [COUNT_W-1:0] COUNT_INIT      = 5'd16;

  // Request kinds.
  localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
  localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
  localparam logic [1:0] REQ_CONTROL  = 2'd2;

  // Result actions.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STOP  = 1'b1;

  // Controller and reset constants.
  localparam logic [CTRL_W-1:0]  CTRL_VOLUME = 7'd7;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 7'd127;
  localparam logic [STAMP_W-1:0] STAMP_INIT  = 32'd1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NOTE_W-1:0] note_number;
    logic [CTRL_W-1:0] control_number;
    logic [CTRL_W-1:0] control_value;
  } req_t;

  typedef struct packed {
    logic               action;
    logic [VIDX_W-1:0]  voice_index;
    logic [NOTE_W-1:0]  played_note;
    logic [LEVEL_W-1:0] level;
    logic               stolen;
  } result_t;

  typedef struct packed {
    logic [NOTE_W-1:0]  note;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_cmd_t;

endpackage

### sv/pva_ram.sv
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/pva_ctrl.sv
module pva_ctrl
  import pva_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  req_t               req,
  input  logic [COUNT_W-1:0] voice_count,
  output logic               busy,
  output result_t            result,
  output logic               result_valid,
  output ram_cmd_t           ram_cmd,
  input  entry_t             ram_rdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state;
  logic [MAX_VOICES-1:0] valid;
  logic [STAMP_W-1:0]   stamp_counter;
  logic [LEVEL_W-1:0]   volume;
  logic                 issue_on;
  logic [IDX_W-1:0]     scan_addr;
  logic                 chk_vld;
  logic [IDX_W-1:0]     chk_idx;
  logic [STAMP_W-1:0]   best_age;
  logic [IDX_W-1:0]     best_idx;
  req_t                 cur;

  logic                 accept;
  logic [IDX_W-1:0]     last_idx;
  logic                 free_any;
  logic [IDX_W-1:0]     free_idx;
  logic [STAMP_W-1:0]   age;
  logic                 take;
  logic [IDX_W-1:0]     pick_idx;
  logic                 is_last;
  logic                 match;
  logic                 steal_end;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Clamp the register to the range 1..MAX_VOICES and keep the last index.
  always_comb begin
    if (voice_count == '0) begin
      last_idx = '0;
    end else if (int'(voice_count) > MAX_VOICES) begin
      last_idx = IDX_W'(MAX_VOICES - 1);
    end else begin
      last_idx = IDX_W'(voice_count - COUNT_W'(1));
    end
  end

  // Lowest free voice within the active range.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MAX_VOICES - 1; i >= 0; i--) begin
      if (!valid[i] && (IDX_W'(i) <= last_idx)) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign age       = stamp_counter - ram_rdata.stamp;
  assign take      = (chk_idx == '0) || (age > best_age);
  assign pick_idx  = take ? chk_idx : best_idx;
  assign is_last   = (chk_idx == last_idx);
  assign match     = valid[chk_idx] && (ram_rdata.note == cur.note_number);
  assign steal_end = (state == ST_SCAN) && chk_vld && (cur.req_type == REQ_NOTE_ON) && is_last;

  always_comb begin
    ram_cmd.raddr       = scan_addr;
    ram_cmd.we          = 1'b0;
    ram_cmd.waddr       = free_idx;
    ram_cmd.wdata.note  = req.note_number;
    ram_cmd.wdata.stamp = stamp_counter;
    if (accept && (req.req_type == REQ_NOTE_ON) && free_any) begin
      ram_cmd.we = 1'b1;
    end
    if (steal_end) begin
      ram_cmd.we         = 1'b1;
      ram_cmd.waddr      = pick_idx;
      ram_cmd.wdata.note = cur.note_number;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      valid         <= '0;
      stamp_counter <= STAMP_INIT;
      volume        <= LEVEL_FULL;
      issue_on      <= 1'b0;
      scan_addr     <= '0;
      chk_vld       <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      chk_vld      <= (state == ST_SCAN) && issue_on;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.req_type)
              REQ_NOTE_ON: begin
                if (free_any) begin
                  valid[free_idx] <= 1'b1;
                  stamp_counter   <= stamp_counter + STAMP_W'(1);
                  result_valid    <= 1'b1;
                end else begin
                  state     <= ST_SCAN;
                  scan_addr <= '0;
                  issue_on  <= 1'b1;
                end
              end
              REQ_NOTE_OFF: begin
                state     <= ST_SCAN;
                scan_addr <= '0;
                issue_on  <= 1'b1;
              end
              REQ_CONTROL: begin
                if (req.control_number == CTRL_VOLUME) begin
                  volume <= req.control_value;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (issue_on) begin
            if (scan_addr == last_idx) begin
              issue_on <= 1'b0;
            end else begin
              scan_addr <= scan_addr + IDX_W'(1);
            end
          end
          if (chk_vld) begin
            if (cur.req_type == REQ_NOTE_ON) begin
              if (is_last) begin
                valid[pick_idx] <= 1'b1;
                stamp_counter   <= stamp_counter + STAMP_W'(1);
                result_valid    <= 1'b1;
                state           <= ST_IDLE;
                issue_on        <= 1'b0;
                chk_vld         <= 1'b0;
              end
            end else if (match) begin
              valid[chk_idx] <= 1'b0;
              result_valid   <= 1'b1;
              state          <= ST_IDLE;
              issue_on       <= 1'b0;
              chk_vld        <= 1'b0;
            end else if (is_last) begin
              state    <= ST_IDLE;
              issue_on <= 1'b0;
              chk_vld  <= 1'b0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    chk_idx <= scan_addr;
    if (accept) begin
      cur <= req;
      if ((req.req_type == REQ_NOTE_ON) && free_any) begin
        result.action      <= ACT_START;
        result.voice_index <= VIDX_W'(free_idx);
        result.played_note <= req.note_number;
        result.level       <= volume;
        result.stolen      <= 1'b0;
      end
    end
    if ((state == ST_SCAN) && chk_vld) begin
      if (cur.req_type == REQ_NOTE_ON) begin
        best_age <= take ? age : best_age;
        best_idx <= pick_idx;
        result.action      <= ACT_START;
        result.voice_index <= VIDX_W'(pick_idx);
        result.played_note <= cur.note_number;
        result.level       <= volume;
        result.stolen      <= 1'b1;
      end else begin
        result.action      <= ACT_STOP;
        result.voice_index <= VIDX_W'(chk_idx);
        result.played_note <= cur.note_number;
        result.level       <= '0;
        result.stolen      <= 1'b0;
      end
    end
  end

endmodule

### sv/poly_voice_allocator_top.sv
// A note-on that finds a free voice, and a control change, leave the allocator idle: the
// note-on's result strobe comes in the cycle after the transfer, a control change gives
// no result, and a new item may follow at once. A note-off or a note-on that steals scans
// the n active voices through the voice RAM, one read a cycle. Reset is synchronous and
// active high; it clears the voice valid bits and sets the stamp counter to one and the
// level to full, without a RAM clearing pass. The receiver cannot stall results.
module poly_voice_allocator_top
  import pva_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              start,
  input  req_t              req,
  output logic              busy,
  output result_t           result,
  output logic              result_valid
);

  logic [COUNT_W-1:0] voice_count;
  logic               cfg_write;
  ram_cmd_t           ram_cmd;
  entry_t             ram_rdata;

  // The configuration port answers every transfer in its access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Voice count. Writes must come only while the allocator is idle; this is unchecked.
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_count <= COUNT_INIT;
    end else if (cfg_write && (paddr == ADDR_VOICE_COUNT)) begin
      voice_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_VOICE_COUNT) ? DATA_W'(voice_count) : '0;

  // The controller owns the valid bits, the stamp counter and the level, and drives the
  // single read and write port of the voice RAM. A scan reads one entry per cycle and sees
  // its data in the next cycle; the only RAM write of an item happens as it finishes, before
  // the next item can issue a read, so no forwarding path is needed.
  pva_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .voice_count  (voice_count),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid),
    .ram_cmd      (ram_cmd),
    .ram_rdata    (ram_rdata)
  );

  // Each entry holds the note and the start stamp of one voice. Entries of free voices are
  // never consulted, so the RAM needs no reset.
  pva_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_VOICES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_cmd.we),
    .waddr (ram_cmd.waddr),
    .wdata (ram_cmd.wdata),
    .raddr (ram_cmd.raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  // A stop result never carries a level or a steal flag.
  a_stop_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.action == ACT_STOP)) |-> ((result.level == '0) && !result.stolen))
    else $error("stop result carries level or steal flag");

  // A result follows either a transfer or a scan in progress.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy || start))
    else $error("result without a transfer or scan");

  // Only note-on and note-off requests start a scan.
  a_scan_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ($past(start) && (($past(req.req_type) == REQ_NOTE_ON) ||
                                     ($past(req.req_type) == REQ_NOTE_OFF))))
    else $error("scan started by an unexpected request");
`endif

endmodule
